FILE: design/bba_pkg.sv
package bba_pkg;

    localparam int TOP_ORDER  = 10;
    localparam int UNIT_BITS  = 15;
    localparam int FM_DEPTH   = 2047;
    localparam int FM_AW      = 11;
    localparam int TAG_DEPTH  = 32768;
    localparam int TAG_W      = 5;
    localparam int WORD_W     = 32;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_INVALID      = 3'd1,
        ST_TOO_LARGE    = 3'd2,
        ST_NO_BLOCK     = 3'd3,
        ST_ALREADY_FREE = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_ORDER,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_SPLIT_RD,
        S_SPLIT_WR,
        S_TAG_WR,
        S_FREE_TAG,
        S_MERGE_RD,
        S_MERGE_CHK,
        S_SET_RD,
        S_SET_WR,
        S_DONE
    } state_t;

    // word address of the node of block blk at order ord; orders are stacked from order 0 up
    function automatic logic [FM_AW-1:0] fm_addr(input logic [3:0] ord,
                                                 input logic [UNIT_BITS-1:0] blk);
        logic [11:0] base;
        base = 12'd2048 - (12'd2048 >> ord);
        return base[FM_AW-1:0] + {1'b0, blk[UNIT_BITS-1:5]};
    endfunction

endpackage

FILE: design/buddy_block_allocator_core.sv
// one request at a time; in_ready is high only while idle
// allocate: check, pick an order, scan free-map words for a free bit, split down to the needed order, write the tag
// free: check, read the tag, merge with each free buddy up the orders, then mark the merged block free
// results sit in an output register, so the next request is taken while one waits
// after reset a clearing pass sweeps both memories before in_ready rises
module buddy_block_allocator_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [6:0]  header_bytes,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        kind,
    input  logic [26:0] request_size,
    input  logic [21:0] data_offset,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic [21:0] granted_offset,
    output logic [3:0]  granted_order
);

    bba_pkg::state_t  state_reg, state_next;
    logic [14:0]      clr_reg, clr_next;
    logic [6:0]       hdr_reg;
    logic             kind_reg;
    logic [26:0]      size_reg;
    logic [21:0]      off_reg;
    logic [3:0]       ord_reg, ord_next;
    logic [3:0]       need_reg, need_next;
    logic [14:0]      blk_reg, blk_next;
    logic [9:0]       word_reg, word_next;
    logic [14:0]      unit_reg, unit_next;
    bba_pkg::status_t st_reg, st_next;
    logic [21:0]      gofs_reg, gofs_next;
    logic [3:0]       gord_reg, gord_next;
    logic [15:0]      cnt_reg [11];
    logic [15:0]      cnt_next [11];
    logic             out_valid_reg, out_valid_next;
    logic [2:0]       out_st_reg;
    logic [21:0]      out_ofs_reg;
    logic [3:0]       out_ord_reg;

    logic             fm_we;
    logic [10:0]      fm_waddr, fm_raddr;
    logic [31:0]      fm_wdata, fm_rdata;
    logic             tag_we;
    logic [14:0]      tag_waddr, tag_raddr;
    logic [4:0]       tag_wdata, tag_rdata;

    logic             accept, out_free;
    logic             size_bad, too_large;
    logic [27:0]      total;
    logic [3:0]       need_c;
    logic [10:0]      nonempty, cand;
    logic [3:0]       pick;
    logic             off_lt, misaligned;
    logic [21:0]      start;
    logic             word_hit, word_last;
    logic [4:0]       low_bit;
    logic [14:0]      split_blk, bud_blk, alloc_unit;
    logic             bud_free, tag_bad;
    logic [3:0]       ord_dn, tag_ord;
    logic             cnt_inc, cnt_dec;
    logic [3:0]       cnt_idx;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == bba_pkg::S_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;

    assign size_bad  = (size_reg == 27'd0) || (size_reg > 27'd100000000);
    assign total     = {1'b0, size_reg} + {21'd0, hdr_reg};
    assign too_large = total > 28'd131072;

    always_comb
    begin
        need_c = 4'd0;
        for (int n = 0; n < bba_pkg::TOP_ORDER; n++)
        begin
            if ((28'd128 << n) < total)
            begin
                need_c = need_c + 4'd1;
            end
        end
    end

    always_comb
    begin
        for (int o = 0; o < 11; o++)
        begin
            nonempty[o] = (cnt_reg[o] != 16'd0);
        end
        cand = nonempty & ~((11'd1 << need_reg) - 11'd1);
        pick = 4'd0;
        for (int o = 10; o >= 0; o--)
        begin
            if (cand[o])
            begin
                pick = o[3:0];
            end
        end
    end

    assign off_lt     = off_reg < {15'd0, hdr_reg};
    assign start      = off_reg - {15'd0, hdr_reg};
    assign misaligned = (start[6:0] != 7'd0);

    always_comb
    begin
        low_bit = 5'd0;
        for (int i = 31; i >= 0; i--)
        begin
            if (fm_rdata[i])
            begin
                low_bit = i[4:0];
            end
        end
    end

    assign word_hit   = (fm_rdata != 32'd0);
    assign word_last  = (word_reg == (10'h3FF >> ord_reg));
    assign ord_dn     = ord_reg - 4'd1;
    assign split_blk  = {blk_reg[13:0], 1'b1};
    assign bud_blk    = blk_reg ^ 15'd1;
    assign bud_free   = fm_rdata[bud_blk[4:0]];
    assign alloc_unit = blk_reg << need_reg;
    assign tag_bad    = (tag_rdata == 5'd0) || (tag_rdata > 5'd11);
    assign tag_ord    = tag_rdata[3:0] - 4'd1;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bba_pkg::S_CLEAR:
            begin
                if (clr_reg == 15'h7FFF)
                begin
                    state_next = bba_pkg::S_IDLE;
                end
            end
            bba_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    state_next = bba_pkg::S_CHECK;
                end
            end
            bba_pkg::S_CHECK:
            begin
                if (!kind_reg)
                begin
                    state_next = (size_bad || too_large) ? bba_pkg::S_DONE : bba_pkg::S_ORDER;
                end
                else
                begin
                    state_next = (off_lt || misaligned) ? bba_pkg::S_DONE : bba_pkg::S_FREE_TAG;
                end
            end
            bba_pkg::S_ORDER:
            begin
                state_next = (cand == 11'd0) ? bba_pkg::S_DONE : bba_pkg::S_SCAN_RD;
            end
            bba_pkg::S_SCAN_RD:
            begin
                state_next = bba_pkg::S_SCAN_CHK;
            end
            bba_pkg::S_SCAN_CHK:
            begin
                if (word_hit)
                begin
                    state_next = (ord_reg > need_reg) ? bba_pkg::S_SPLIT_RD : bba_pkg::S_TAG_WR;
                end
                else
                begin
                    state_next = word_last ? bba_pkg::S_DONE : bba_pkg::S_SCAN_RD;
                end
            end
            bba_pkg::S_SPLIT_RD:
            begin
                state_next = bba_pkg::S_SPLIT_WR;
            end
            bba_pkg::S_SPLIT_WR:
            begin
                state_next = (ord_dn > need_reg) ? bba_pkg::S_SPLIT_RD : bba_pkg::S_TAG_WR;
            end
            bba_pkg::S_TAG_WR:
            begin
                state_next = bba_pkg::S_DONE;
            end
            bba_pkg::S_FREE_TAG:
            begin
                if (tag_bad)
                begin
                    state_next = bba_pkg::S_DONE;
                end
                else
                begin
                    state_next = (tag_ord == 4'd10) ? bba_pkg::S_SET_RD : bba_pkg::S_MERGE_RD;
                end
            end
            bba_pkg::S_MERGE_RD:
            begin
                state_next = bba_pkg::S_MERGE_CHK;
            end
            bba_pkg::S_MERGE_CHK:
            begin
                if (bud_free && ord_reg != 4'd9)
                begin
                    state_next = bba_pkg::S_MERGE_RD;
                end
                else
                begin
                    state_next = bba_pkg::S_SET_RD;
                end
            end
            bba_pkg::S_SET_RD:
            begin
                state_next = bba_pkg::S_SET_WR;
            end
            bba_pkg::S_SET_WR:
            begin
                state_next = bba_pkg::S_DONE;
            end
            bba_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    state_next = bba_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = bba_pkg::S_IDLE;
            end
        endcase
    end

    // datapath and memory controls
    always_comb
    begin
        clr_next   = clr_reg;
        ord_next   = ord_reg;
        need_next  = need_reg;
        blk_next   = blk_reg;
        word_next  = word_reg;
        unit_next  = unit_reg;
        st_next    = st_reg;
        gofs_next  = gofs_reg;
        gord_next  = gord_reg;
        fm_we      = 1'b0;
        fm_waddr   = bba_pkg::fm_addr(ord_reg, blk_reg);
        fm_wdata   = fm_rdata;
        fm_raddr   = bba_pkg::fm_addr(ord_reg, blk_reg);
        tag_we     = 1'b0;
        tag_waddr  = unit_reg;
        tag_wdata  = 5'd0;
        tag_raddr  = start[21:7];
        cnt_inc    = 1'b0;
        cnt_dec    = 1'b0;
        cnt_idx    = ord_reg;
        case (state_reg)
            bba_pkg::S_CLEAR:
            begin
                clr_next  = clr_reg + 15'd1;
                fm_we     = (clr_reg < 15'd2047);
                fm_waddr  = clr_reg[10:0];
                fm_wdata  = (clr_reg[10:0] == 11'd2046) ? 32'hFFFF_FFFF : 32'd0;
                tag_we    = 1'b1;
                tag_waddr = clr_reg;
            end
            bba_pkg::S_IDLE:
            begin
                st_next   = bba_pkg::ST_OK;
                gofs_next = 22'd0;
                gord_next = 4'd0;
            end
            bba_pkg::S_CHECK:
            begin
                if (!kind_reg)
                begin
                    need_next = need_c;
                    if (size_bad)
                    begin
                        st_next = bba_pkg::ST_INVALID;
                    end
                    else if (too_large)
                    begin
                        st_next = bba_pkg::ST_TOO_LARGE;
                    end
                end
                else
                begin
                    unit_next = start[21:7];
                    if (off_lt || misaligned)
                    begin
                        st_next = bba_pkg::ST_ALREADY_FREE;
                    end
                end
            end
            bba_pkg::S_ORDER:
            begin
                ord_next  = pick;
                word_next = 10'd0;
                if (cand == 11'd0)
                begin
                    st_next = bba_pkg::ST_NO_BLOCK;
                end
            end
            bba_pkg::S_SCAN_RD:
            begin
                fm_raddr = bba_pkg::fm_addr(ord_reg, {word_reg, 5'd0});
            end
            bba_pkg::S_SCAN_CHK:
            begin
                fm_waddr = bba_pkg::fm_addr(ord_reg, {word_reg, 5'd0});
                if (word_hit)
                begin
                    fm_we    = 1'b1;
                    fm_wdata = fm_rdata & ~(32'd1 << low_bit);
                    cnt_dec  = 1'b1;
                    blk_next = {word_reg, low_bit};
                end
                else
                begin
                    word_next = word_reg + 10'd1;
                    if (word_last)
                    begin
                        st_next = bba_pkg::ST_NO_BLOCK;
                    end
                end
            end
            bba_pkg::S_SPLIT_RD:
            begin
                fm_raddr = bba_pkg::fm_addr(ord_dn, split_blk);
            end
            bba_pkg::S_SPLIT_WR:
            begin
                // free the upper half one order down
                fm_we    = 1'b1;
                fm_waddr = bba_pkg::fm_addr(ord_dn, split_blk);
                fm_wdata = fm_rdata | (32'd1 << split_blk[4:0]);
                cnt_inc  = 1'b1;
                cnt_idx  = ord_dn;
                blk_next = {blk_reg[13:0], 1'b0};
                ord_next = ord_dn;
            end
            bba_pkg::S_TAG_WR:
            begin
                tag_we    = 1'b1;
                tag_waddr = alloc_unit;
                tag_wdata = {1'b0, need_reg} + 5'd1;
                gofs_next = {alloc_unit, 7'd0} + {15'd0, hdr_reg};
                gord_next = need_reg;
            end
            bba_pkg::S_FREE_TAG:
            begin
                if (tag_bad)
                begin
                    st_next = bba_pkg::ST_ALREADY_FREE;
                end
                else
                begin
                    tag_we    = 1'b1;
                    ord_next  = tag_ord;
                    gord_next = tag_ord;
                    blk_next  = unit_reg >> tag_ord;
                end
            end
            bba_pkg::S_MERGE_RD:
            begin
                fm_raddr = bba_pkg::fm_addr(ord_reg, bud_blk);
            end
            bba_pkg::S_MERGE_CHK:
            begin
                fm_waddr = bba_pkg::fm_addr(ord_reg, bud_blk);
                if (bud_free)
                begin
                    fm_we    = 1'b1;
                    fm_wdata = fm_rdata & ~(32'd1 << bud_blk[4:0]);
                    cnt_dec  = 1'b1;
                    blk_next = blk_reg >> 1;
                    ord_next = ord_reg + 4'd1;
                end
            end
            bba_pkg::S_SET_RD:
            begin
                fm_raddr = bba_pkg::fm_addr(ord_reg, blk_reg);
            end
            bba_pkg::S_SET_WR:
            begin
                fm_we    = 1'b1;
                fm_wdata = fm_rdata | (32'd1 << blk_reg[4:0]);
                cnt_inc  = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // free-block count per order, so the allocate knows which order to scan
    always_comb
    begin
        for (int o = 0; o < 11; o++)
        begin
            cnt_next[o] = cnt_reg[o];
        end
        if (cnt_inc)
        begin
            cnt_next[cnt_idx] = cnt_reg[cnt_idx] + 16'd1;
        end
        else if (cnt_dec)
        begin
            cnt_next[cnt_idx] = cnt_reg[cnt_idx] - 16'd1;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        if (state_reg == bba_pkg::S_DONE && out_free)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bba_pkg::S_CLEAR;
            clr_reg       <= 15'd0;
            hdr_reg       <= 7'd48;
            out_valid_reg <= 1'b0;
            for (int o = 0; o < 11; o++)
            begin
                cnt_reg[o] <= (o == 10) ? 16'd32 : 16'd0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
            if (cfg_valid && cfg_ready)
            begin
                hdr_reg <= header_bytes;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ord_reg  <= ord_next;
        need_reg <= need_next;
        blk_reg  <= blk_next;
        word_reg <= word_next;
        unit_reg <= unit_next;
        st_reg   <= st_next;
        gofs_reg <= gofs_next;
        gord_reg <= gord_next;
        if (accept)
        begin
            kind_reg <= kind;
            size_reg <= request_size;
            off_reg  <= data_offset;
        end
        if (state_reg == bba_pkg::S_DONE && out_free)
        begin
            out_st_reg  <= st_reg;
            out_ofs_reg <= gofs_reg;
            out_ord_reg <= gord_reg;
        end
    end

    bba_ram #(
        .WIDTH(bba_pkg::WORD_W),
        .DEPTH(bba_pkg::FM_DEPTH)
    ) u_free_map (
        .clk  (clk),
        .we   (fm_we),
        .waddr(fm_waddr),
        .wdata(fm_wdata),
        .raddr(fm_raddr),
        .rdata(fm_rdata)
    );

    bba_ram #(
        .WIDTH(bba_pkg::TAG_W),
        .DEPTH(bba_pkg::TAG_DEPTH)
    ) u_block_tag (
        .clk  (clk),
        .we   (tag_we),
        .waddr(tag_waddr),
        .wdata(tag_wdata),
        .raddr(tag_raddr),
        .rdata(tag_rdata)
    );

    assign out_valid      = out_valid_reg;
    assign status         = out_st_reg;
    assign granted_offset = out_ofs_reg;
    assign granted_order  = out_ord_reg;

endmodule

FILE: design/bba_ram.sv
module bba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: design/bba_checker.sv
module bba_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  status,
    input logic [21:0] granted_offset,
    input logic [3:0]  granted_order
);

    // a word that waits is not dropped
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status))
        else $error("result word dropped or changed while stalled");

    // one request in flight at a time
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second request taken while busy");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status <= bba_pkg::ST_ALREADY_FREE && granted_order <= 4'd10)
        else $error("status or order out of range");

    // a rejected request carries no offset or order
    a_reject_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != bba_pkg::ST_OK |-> granted_offset == 22'd0
            && granted_order == 4'd0)
        else $error("rejected request reports a block");

endmodule

bind buddy_block_allocator_core bba_checker u_bba_checker (.*);

FILE: tb/sv/buddy_block_allocator_core_test.sv
`timescale 1ns / 1ps

module buddy_block_allocator_core_test;

    localparam int NODES_TOP  = 2047;
    localparam int TOP_CNT    = 32;
    localparam int UNITS      = 32768;
    localparam int TOP_BYTES  = 131072;
    localparam int SIZE_MAX   = 100000000;
    localparam int DOG_LIMIT  = 120000;
    localparam int LONG_HOLD  = 4000;

    typedef enum logic [1:0] {
        SRC_LIT,
        SRC_LIVE,
        SRC_DEAD,
        SRC_STALE
    } src_t;

    typedef struct {
        logic        kind;
        logic [26:0] size;
        logic [21:0] offset;
        src_t        src;
    } req_t;

    typedef struct {
        bba_pkg::status_t st;
        logic [21:0]      offset;
        logic [3:0]       order;
    } grant_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [6:0]  header_bytes = 7'd0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        kind = 1'b0;
    logic [26:0] request_size = 27'd0;
    logic [21:0] data_offset = 22'd0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [2:0]  status;
    logic [21:0] granted_offset;
    logic [3:0]  granted_order;

    buddy_block_allocator_core dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .header_bytes(header_bytes),
        .in_valid(in_valid), .in_ready(in_ready),
        .kind(kind), .request_size(request_size), .data_offset(data_offset),
        .out_valid(out_valid), .out_ready(out_ready),
        .status(status), .granted_offset(granted_offset), .granted_order(granted_order)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // allocator shadow state
    bit          node_free [0:TOP_CNT*NODES_TOP-1];
    logic [4:0]  unit_tag [0:UNITS-1];
    int          free_per_order [0:bba_pkg::TOP_ORDER];
    logic [6:0]  hdr_now;
    logic [6:0]  hdr_prev;

    req_t        pend_q[$];
    grant_t      grant_q[$];
    int          live_units[$];
    int          dead_units[$];

    int errors = 0;
    int n_alloc_ok = 0, n_free_ok = 0, n_results = 0;
    int n_status [0:7];
    int n_phases = 0;

    function automatic int node_idx(int ord, int blk);
        int lvl;
        lvl = bba_pkg::TOP_ORDER - ord;
        return (blk >> lvl) * NODES_TOP + ((1 << lvl) - 1) + (blk & ((1 << lvl) - 1));
    endfunction

    task automatic mark(int ord, int blk, bit v);
        int n;
        n = node_idx(ord, blk);
        if (node_free[n] != v)
            free_per_order[ord] += v ? 1 : -1;
        node_free[n] = v;
    endtask

    task automatic shadow_reset();
        foreach (node_free[i]) node_free[i] = 1'b0;
        foreach (unit_tag[i]) unit_tag[i] = 5'd0;
        foreach (free_per_order[i]) free_per_order[i] = 0;
        for (int t = 0; t < TOP_CNT; t++) node_free[t * NODES_TOP] = 1'b1;
        free_per_order[bba_pkg::TOP_ORDER] = TOP_CNT;
        hdr_now = 7'd48;
        hdr_prev = 7'd48;
    endtask

    task automatic grant_alloc(logic [26:0] size, inout grant_t g);
        longint total;
        int need, ord, blk, cnt, unit;
        bit found;
        found = 0;
        blk = 0;
        if (size == 0 || size > SIZE_MAX) begin
            g.st = bba_pkg::ST_INVALID;
            return;
        end
        total = longint'(size) + hdr_now;
        if (total > TOP_BYTES) begin
            g.st = bba_pkg::ST_TOO_LARGE;
            return;
        end
        need = 0;
        while (need < bba_pkg::TOP_ORDER && (longint'(128) << need) < total) need++;
        for (ord = need; ord <= bba_pkg::TOP_ORDER; ord++) begin
            if (free_per_order[ord] != 0) begin
                cnt = TOP_CNT << (bba_pkg::TOP_ORDER - ord);
                for (blk = 0; blk < cnt; blk++)
                    if (node_free[node_idx(ord, blk)]) begin
                        found = 1;
                        break;
                    end
            end
            if (found) break;
        end
        if (!found) begin
            g.st = bba_pkg::ST_NO_BLOCK;
            return;
        end
        mark(ord, blk, 1'b0);
        for (int j = ord; j > need; j--) begin
            mark(j - 1, 2 * blk + 1, 1'b1);
            blk = 2 * blk;
        end
        unit = blk << need;
        unit_tag[unit] = 5'(need + 1);
        live_units.push_back(unit);
        g.st = bba_pkg::ST_OK;
        g.offset = 22'(unit * 128 + hdr_now);
        g.order = 4'(need);
    endtask

    task automatic grant_free(logic [21:0] off, inout grant_t g);
        int start, unit, ord, blk;
        if (off < hdr_now) begin
            g.st = bba_pkg::ST_ALREADY_FREE;
            return;
        end
        start = int'(off) - hdr_now;
        unit = start / 128;
        if (start % 128 != 0 || unit >= UNITS || unit_tag[unit] == 0
                || unit_tag[unit] > bba_pkg::TOP_ORDER + 1) begin
            g.st = bba_pkg::ST_ALREADY_FREE;
            return;
        end
        ord = unit_tag[unit] - 1;
        g.order = 4'(ord);
        unit_tag[unit] = 5'd0;
        blk = unit >> ord;
        while (ord < bba_pkg::TOP_ORDER) begin
            if (!node_free[node_idx(ord, blk ^ 1)]) break;
            mark(ord, blk ^ 1, 1'b0);
            blk >>= 1;
            ord++;
        end
        mark(ord, blk, 1'b1);
        g.st = bba_pkg::ST_OK;
        foreach (live_units[i])
            if (live_units[i] == unit) begin
                live_units.delete(i);
                break;
            end
        dead_units.push_back(unit);
        if (dead_units.size() > 64) void'(dead_units.pop_front());
    endtask

    task automatic predict_grant(req_t r);
        grant_t g;
        g.st = bba_pkg::ST_OK;
        g.offset = 22'd0;
        g.order = 4'd0;
        if (!r.kind) grant_alloc(r.size, g);
        else grant_free(r.offset, g);
        if (g.st == bba_pkg::ST_OK) begin
            if (r.kind) n_free_ok++;
            else n_alloc_ok++;
        end
        grant_q.push_back(g);
    endtask

    // sender: bursts with random gaps, free targets resolved against live or freed blocks at launch
    req_t cur_req;
    int   burst_left = 1;
    int   gap_left = 0;

    function automatic req_t resolve(req_t r);
        int u;
        if (r.src == SRC_LIVE && live_units.size() != 0) begin
            u = live_units[$urandom_range(0, live_units.size() - 1)];
            r.offset = 22'(u * 128 + hdr_now);
        end else if (r.src == SRC_DEAD && dead_units.size() != 0) begin
            u = dead_units[$urandom_range(0, dead_units.size() - 1)];
            r.offset = 22'(u * 128 + hdr_now);
        end else if (r.src == SRC_STALE && live_units.size() != 0) begin
            u = live_units[$urandom_range(0, live_units.size() - 1)];
            r.offset = 22'(u * 128 + hdr_prev + $urandom_range(0, 2));
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready) predict_grant(cur_req);
            if (!in_valid || in_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_valid <= 1'b0;
                end else if (pend_q.size() != 0) begin
                    cur_req = resolve(pend_q.pop_front());
                    kind <= cur_req.kind;
                    request_size <= cur_req.size;
                    data_offset <= cur_req.offset;
                    in_valid <= 1'b1;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 30);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
                    end
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: stall rate changes per window, plus one long hold-off
    int stall_pct = 0;
    int win_cnt = 0;
    int hold_cnt = 0;
    bit hold_done = 0;

    always @(posedge clk or negedge rst_n) begin
        grant_t e;
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                n_results++;
                if (grant_q.size() == 0) begin
                    $display("%0t: unexpected word status=%0d offset=%0d order=%0d",
                             $time, status, granted_offset, granted_order);
                    errors++;
                end else begin
                    e = grant_q.pop_front();
                    n_status[e.st]++;
                    if (status !== e.st) begin
                        $display("%0t: status expected %0d actual %0d", $time, e.st, status);
                        errors++;
                    end
                    if (granted_offset !== e.offset) begin
                        $display("%0t: granted_offset expected %0d actual %0d",
                                 $time, e.offset, granted_offset);
                        errors++;
                    end
                    if (granted_order !== e.order) begin
                        $display("%0t: granted_order expected %0d actual %0d",
                                 $time, e.order, granted_order);
                        errors++;
                    end
                end
            end
            win_cnt++;
            if (win_cnt % 64 == 0)
                case ($urandom_range(0, 3))
                    0, 1: stall_pct = 0;
                    2: stall_pct = 30;
                    default: stall_pct = 75;
                endcase
            if (!hold_done && n_results == 600) begin
                hold_done = 1;
                hold_cnt = LONG_HOLD;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    // watchdog on cycles with no word moving on any channel
    int quiet = 0;
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet = 0;
        else
            quiet++;
        if (quiet >= DOG_LIMIT) begin
            $display("%0t: watchdog, no progress for %0d cycles", $time, quiet);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic req_t mk(logic k, logic [26:0] s, logic [21:0] o, src_t src);
        req_t r;
        r.kind = k;
        r.size = s;
        r.offset = o;
        r.src = src;
        return r;
    endfunction

    task automatic wait_idle();
        while (pend_q.size() != 0 || in_valid || grant_q.size() != 0) @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    task automatic write_hdr(logic [6:0] v);
        @(posedge clk);
        cfg_valid <= 1'b1;
        header_bytes <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        hdr_prev = hdr_now;
        hdr_now = v;
    endtask

    task automatic push_random(int n);
        int r;
        logic [26:0] s;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < 8) begin
                pend_q.push_back(mk($urandom_range(0, 1), 27'($urandom), 22'($urandom),
                                    SRC_LIT));
            end else if (r < 47) begin
                case ($urandom_range(0, 19))
                    0: s = 27'(TOP_BYTES - hdr_now);
                    1, 2: s = 27'($urandom_range(1, TOP_BYTES));
                    3, 4, 5, 6, 7: s = 27'($urandom_range(1, 4000));
                    default: s = 27'($urandom_range(1, 200));
                endcase
                pend_q.push_back(mk(1'b0, s, 22'($urandom), SRC_LIT));
            end else if (r < 90) begin
                pend_q.push_back(mk(1'b1, 27'($urandom), 22'd0, SRC_LIVE));
            end else if (r < 96) begin
                pend_q.push_back(mk(1'b1, 27'($urandom), 22'd0, SRC_DEAD));
            end else begin
                pend_q.push_back(mk(1'b1, 27'($urandom), 22'd0, SRC_STALE));
            end
        end
    endtask

    logic [6:0] hdr_plan [0:6] = '{7'd0, 7'd127, 7'd48, 7'd1, 7'd80, 7'd127, 7'd0};

    initial begin
        foreach (n_status[i]) n_status[i] = 0;
        shadow_reset();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed words under the reset header
        pend_q.push_back(mk(1'b0, 27'd0, 22'd0, SRC_LIT));
        pend_q.push_back(mk(1'b0, 27'd100000001, 22'd0, SRC_LIT));
        pend_q.push_back(mk(1'b0, 27'h7FFFFFF, 22'h3FFFFF, SRC_LIT));
        pend_q.push_back(mk(1'b0, 27'd100000000, 22'd0, SRC_LIT));
        pend_q.push_back(mk(1'b0, 27'(TOP_BYTES - 47), 22'd0, SRC_LIT));
        pend_q.push_back(mk(1'b0, 27'(TOP_BYTES - 48), 22'd0, SRC_LIT));
        pend_q.push_back(mk(1'b0, 27'd1, 22'd0, SRC_LIT));
        pend_q.push_back(mk(1'b0, 27'd80, 22'd0, SRC_LIT));
        pend_q.push_back(mk(1'b0, 27'd81, 22'd0, SRC_LIT));
        pend_q.push_back(mk(1'b0, 27'd5000, 22'd0, SRC_LIT));
        pend_q.push_back(mk(1'b1, 27'd0, 22'd0, SRC_LIT));
        pend_q.push_back(mk(1'b1, 27'd0, 22'd47, SRC_LIT));
        pend_q.push_back(mk(1'b1, 27'd0, 22'd49, SRC_LIT));
        pend_q.push_back(mk(1'b1, 27'd0, 22'(UNITS * 128 + 48), SRC_LIT));
        pend_q.push_back(mk(1'b1, 27'd0, 22'h3FFFFF, SRC_LIT));
        pend_q.push_back(mk(1'b1, 27'd0, 22'd48 + 22'd128, SRC_LIT));
        pend_q.push_back(mk(1'b1, 27'd0, 22'd48, SRC_LIT));
        pend_q.push_back(mk(1'b1, 27'd0, 22'd48, SRC_LIT));
        pend_q.push_back(mk(1'b1, 27'd0, 22'd0, SRC_LIVE));
        pend_q.push_back(mk(1'b1, 27'd0, 22'd0, SRC_LIVE));
        pend_q.push_back(mk(1'b1, 27'd0, 22'd0, SRC_DEAD));
        pend_q.push_back(mk(1'b1, 27'd0, 22'd0, SRC_LIVE));
        pend_q.push_back(mk(1'b1, 27'd0, 22'd0, SRC_LIVE));
        wait_idle();

        for (int p = 0; p < 7; p++) begin
            write_hdr(hdr_plan[p] == 7'd80 ? 7'($urandom_range(0, 127)) : hdr_plan[p]);
            n_phases++;
            if (p == 3) begin
                // drain the arena with top-order grants, then hand everything back
                for (int i = 0; i < 38; i++)
                    pend_q.push_back(mk(1'b0, 27'(TOP_BYTES - hdr_now), 22'd0, SRC_LIT));
                pend_q.push_back(mk(1'b0, 27'd1, 22'd0, SRC_LIT));
                for (int i = 0; i < 70; i++)
                    pend_q.push_back(mk(1'b1, 27'd0, 22'd0, SRC_LIVE));
            end else begin
                push_random(270);
            end
            wait_idle();
        end

        $display("covered %0d phases, %0d results: %0d grants, %0d frees ok",
                 n_phases + 1, n_results, n_alloc_ok, n_free_ok);
        $display("status mix invalid=%0d too_large=%0d no_block=%0d already_free=%0d",
                 n_status[bba_pkg::ST_INVALID], n_status[bba_pkg::ST_TOO_LARGE],
                 n_status[bba_pkg::ST_NO_BLOCK], n_status[bba_pkg::ST_ALREADY_FREE]);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: filelist.f
design/bba_pkg.sv
design/bba_ram.sv
design/buddy_block_allocator_core.sv
design/bba_checker.sv
tb/sv/buddy_block_allocator_core_test.sv
